// ===== rtl/numeric_type_converter_defines.svh =====
// assertion macros used by the checker of the type converter
`ifndef NUMERIC_TYPE_CONVERTER_DEFINES_SVH
`define NUMERIC_TYPE_CONVERTER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define NTC_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication over the four register ranks from accepting edge to sampled result
`define NTC_CHECK_LAT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##4 (cons)) \
        else $error(msg);

`endif

// ===== rtl/ntc_pkg.sv =====
`default_nettype none
package ntc_pkg;

    // type codes
    localparam logic [3:0] TC_CHAR = 4'd0;
    localparam logic [3:0] TC_I8   = 4'd1;
    localparam logic [3:0] TC_U8   = 4'd2;
    localparam logic [3:0] TC_I16  = 4'd3;
    localparam logic [3:0] TC_U16  = 4'd4;
    localparam logic [3:0] TC_I32  = 4'd5;
    localparam logic [3:0] TC_U32  = 4'd6;
    localparam logic [3:0] TC_I64  = 4'd7;
    localparam logic [3:0] TC_U64  = 4'd8;
    localparam logic [3:0] TC_F32  = 4'd9;
    localparam logic [3:0] TC_F64  = 4'd10;

    typedef enum logic [1:0] {SZ_8, SZ_16, SZ_32, SZ_64} t_size;
    typedef enum logic [1:0] {K_PASS, K_INT_FLT, K_F64_F32, K_FLT_INT} t_kind;

    // after decode and unpack
    typedef struct packed {
        t_kind       kind;
        logic        inv;
        logic        dst_f64;
        t_size       dst_sz;
        logic        dst_sgn;
        logic        sign;
        logic [63:0] val;
    } t_unpk;

    // after normalize and align
    typedef struct packed {
        t_kind       kind;
        logic        inv;
        logic        dst_f64;
        t_size       dst_sz;
        logic        dst_sgn;
        logic        sign;
        logic        nan;
        logic        big;
        logic        grd;
        logic        stk;
        logic [5:0]  lz;
        logic [7:0]  exp8;
        logic [63:0] val;
    } t_mid;

    function automatic logic code_valid(input logic [3:0] c);
        return c <= TC_F64;
    endfunction

    function automatic logic code_signed(input logic [3:0] c);
        logic r;
        case (c)
            TC_U8, TC_U16, TC_U32, TC_U64: r = 1'b0;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic t_size code_size(input logic [3:0] c);
        t_size r;
        case (c)
            TC_CHAR, TC_I8, TC_U8: r = SZ_8;
            TC_I16, TC_U16:        r = SZ_16;
            TC_I32, TC_U32, TC_F32: r = SZ_32;
            default:               r = SZ_64;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] size_mask(input t_size s);
        logic [63:0] r;
        case (s)
            SZ_8:    r = 64'h0000_0000_0000_00FF;
            SZ_16:   r = 64'h0000_0000_0000_FFFF;
            SZ_32:   r = 64'h0000_0000_FFFF_FFFF;
            default: r = '1;
        endcase
        return r;
    endfunction

    // count of leading zeros, zero input gives 0
    function automatic logic [5:0] lead_zeros(input logic [63:0] x);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) n = 6'(63 - i);
        end
        return n;
    endfunction

    // exact single to double widening, nan keeps sign and top payload bits
    function automatic logic [63:0] f32_to_f64(input logic [31:0] b);
        logic        s;
        logic [7:0]  e;
        logic [22:0] f;
        logic [4:0]  p;
        logic [22:0] fn;
        logic [63:0] r;
        s = b[31];
        e = b[30:23];
        f = b[22:0];
        p = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (f[i]) p = 5'(i);
        end
        fn = f << (5'd23 - p);
        if (e == 8'hFF) begin
            r = (f == 23'd0) ? {s, 11'h7FF, 52'd0} : {s, 11'h7FF, 1'b1, f[21:0], 29'd0};
        end else if (e == 8'd0) begin
            r = (f == 23'd0) ? {s, 63'd0} : {s, 11'(p) + 11'd874, fn, 29'd0};
        end else begin
            r = {s, {3'd0, e} + 11'd896, f, 29'd0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ntc_unpack.sv =====
`default_nettype none
module ntc_unpack
    import ntc_pkg::*;
(
    input  wire logic [3:0]  i_source_type,
    input  wire logic [3:0]  i_target_type,
    input  wire logic [63:0] i_source_bits,
    output t_unpk            o_unpk
);

    logic [63:0] v;
    logic [63:0] dbl;
    logic        sx;
    logic        neg;

    // extend integer source, widen single source to double
    always_comb begin
        sx  = code_signed(i_source_type);
        dbl = (i_source_type == TC_F32) ? f32_to_f64(i_source_bits[31:0]) : i_source_bits;
        case (code_size(i_source_type))
            SZ_8:    v = {{56{sx & i_source_bits[7]}}, i_source_bits[7:0]};
            SZ_16:   v = {{48{sx & i_source_bits[15]}}, i_source_bits[15:0]};
            SZ_32:   v = {{32{sx & i_source_bits[31]}}, i_source_bits[31:0]};
            default: v = i_source_bits;
        endcase
        neg = sx & v[63];
    end

    // classify the pair
    always_comb begin
        o_unpk         = '0;
        o_unpk.kind    = K_PASS;
        o_unpk.dst_f64 = (i_target_type == TC_F64);
        o_unpk.dst_sz  = code_size(i_target_type);
        o_unpk.dst_sgn = code_signed(i_target_type);
        if (!code_valid(i_source_type) || !code_valid(i_target_type)) begin
            o_unpk.inv = 1'b1;
        end else if (i_source_type == TC_F32 || i_source_type == TC_F64) begin
            o_unpk.sign = dbl[63];
            if (i_target_type == i_source_type) begin
                o_unpk.val = (i_source_type == TC_F32) ?
                             {32'd0, i_source_bits[31:0]} : i_source_bits;
            end else if (i_target_type == TC_F64) begin
                o_unpk.val = dbl;
            end else if (i_target_type == TC_F32) begin
                o_unpk.kind = K_F64_F32;
                o_unpk.val  = dbl;
            end else begin
                o_unpk.kind = K_FLT_INT;
                o_unpk.val  = dbl;
            end
        end else if (i_target_type == TC_F32 || i_target_type == TC_F64) begin
            o_unpk.kind = K_INT_FLT;
            o_unpk.sign = neg;
            o_unpk.val  = neg ? (64'd0 - v) : v;
        end else begin
            o_unpk.val = v & size_mask(code_size(i_target_type));
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ntc_round.sv =====
`default_nettype none
module ntc_round
    import ntc_pkg::*;
(
    input  t_mid              i_mid,
    output logic [63:0]       o_result_bits,
    output logic              o_range_clipped
);

    logic [63:0] mask;
    logic [63:0] half;
    logic [63:0] top;
    logic        up;
    logic        ge;
    logic [30:0] p32;
    logic [62:0] p64;

    // round, pack and saturate
    always_comb begin
        mask            = size_mask(i_mid.dst_sz);
        half            = mask >> 1;
        top             = half + 64'd1;
        up              = 1'b0;
        ge              = 1'b0;
        p32             = '0;
        p64             = '0;
        o_result_bits   = '0;
        o_range_clipped = 1'b0;
        case (i_mid.kind)
            K_PASS: begin
                o_result_bits = i_mid.val;
            end
            K_INT_FLT: begin
                if (!i_mid.val[63]) begin
                    o_result_bits = '0;
                end else if (!i_mid.dst_f64) begin
                    up  = i_mid.val[39] & ((|i_mid.val[38:0]) | i_mid.val[40]);
                    p32 = {8'd190 - {2'd0, i_mid.lz}, i_mid.val[62:40]} + 31'(up);
                    o_result_bits = {32'd0, i_mid.sign, p32};
                end else begin
                    up  = i_mid.val[10] & ((|i_mid.val[9:0]) | i_mid.val[11]);
                    p64 = {11'd1086 - {5'd0, i_mid.lz}, i_mid.val[62:11]} + 63'(up);
                    o_result_bits = {i_mid.sign, p64};
                end
            end
            K_F64_F32: begin
                if (i_mid.nan) begin
                    o_result_bits = {32'd0, i_mid.sign, 8'hFF, 1'b1, i_mid.val[50:29]};
                end else if (i_mid.big) begin
                    o_result_bits = {32'd0, i_mid.sign, 8'hFF, 23'd0};
                end else begin
                    up  = i_mid.grd & (i_mid.stk | i_mid.val[0]);
                    p32 = {i_mid.exp8, i_mid.val[22:0]} + 31'(up);
                    o_result_bits = {32'd0, i_mid.sign, p32};
                end
            end
            K_FLT_INT: begin
                if (i_mid.nan) begin
                    o_range_clipped = 1'b1;
                end else if (i_mid.dst_sgn) begin
                    ge = i_mid.big | (|(i_mid.val & ~half));
                    if (!i_mid.sign && ge) begin
                        o_result_bits   = half;
                        o_range_clipped = 1'b1;
                    end else if (i_mid.sign && (i_mid.big || (ge && i_mid.val != top))) begin
                        o_result_bits   = top;
                        o_range_clipped = 1'b1;
                    end else begin
                        o_result_bits = (i_mid.sign ? (64'd0 - i_mid.val) : i_mid.val) & mask;
                    end
                end else begin
                    if (i_mid.sign && (i_mid.big || i_mid.val != 64'd0)) begin
                        o_range_clipped = 1'b1;
                    end else if (!i_mid.sign && (i_mid.big || (|(i_mid.val & ~mask)))) begin
                        o_result_bits   = mask;
                        o_range_clipped = 1'b1;
                    end else begin
                        o_result_bits = i_mid.val & mask;
                    end
                end
            end
            default: begin
                o_result_bits = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/numeric_type_converter.sv =====
// Numeric type converter between char, 8/16/32/64-bit signed and unsigned
// integers, IEEE single and IEEE double.
// Input: drive i_source_type, i_target_type and i_source_bits with start high;
// the beat is taken at a rising edge where start is high and busy is low.
// busy is low whenever reset is released, so one beat can enter every cycle.
// Output: each result shows on o_result_bits, o_pair_invalid and
// o_range_clipped for exactly one cycle with o_strobe high. Results come
// back in input order.
// Throughput is one conversion per cycle; the path holds the four
// register ranks: input, unpack, normalize/align, round/pack.
// The receiver cannot stall; a result must be taken in its strobe cycle.
// Unknown type codes give a zero result with o_pair_invalid set.
// Float to integer truncates toward zero and saturates, NaN gives zero;
// either sets o_range_clipped.
// Reset is synchronous, active low; it drops all beats in flight and holds
// busy high while asserted.
`default_nettype none
module numeric_type_converter
    import ntc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_source_type,
    input  wire logic [3:0]  i_target_type,
    input  wire logic [63:0] i_source_bits,
    output logic             o_strobe,
    output logic [63:0]      o_result_bits,
    output logic             o_pair_invalid,
    output logic             o_range_clipped
);

    logic        r_vld_in;
    logic [3:0]  r_st;
    logic [3:0]  r_tt;
    logic [63:0] r_bits;
    logic        r_vld_u;
    t_unpk       n_unpk;
    t_unpk       r_unpk;
    logic        r_vld_m;
    t_mid        n_mid;
    t_mid        r_mid;
    logic        r_strobe;
    logic [63:0] n_res;
    logic        n_clip;
    logic [63:0] r_res;
    logic        r_inv;
    logic        r_clip;

    logic [10:0]  e;
    logic [52:0]  sig;
    logic [5:0]   sh;
    logic [116:0] w;
    logic         nan;

    assign busy = ~i_rst_n;

    // beat valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
            r_vld_u  <= 1'b0;
            r_vld_m  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld_in <= start;
            r_vld_u  <= r_vld_in;
            r_vld_m  <= r_vld_u;
            r_strobe <= r_vld_m;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        r_st   <= i_source_type;
        r_tt   <= i_target_type;
        r_bits <= i_source_bits;
    end

    ntc_unpack u_unpack (
        .i_source_type (r_st),
        .i_target_type (r_tt),
        .i_source_bits (r_bits),
        .o_unpk        (n_unpk)
    );

    always_ff @(posedge i_clk) begin
        r_unpk <= n_unpk;
    end

    // normalize integers, align double mantissa for narrowing or truncation
    always_comb begin
        n_mid         = '0;
        n_mid.kind    = r_unpk.kind;
        n_mid.inv     = r_unpk.inv;
        n_mid.dst_f64 = r_unpk.dst_f64;
        n_mid.dst_sz  = r_unpk.dst_sz;
        n_mid.dst_sgn = r_unpk.dst_sgn;
        n_mid.sign    = r_unpk.sign;
        e   = r_unpk.val[62:52];
        sig = {e != 11'd0, r_unpk.val[51:0]};
        nan = (e == 11'h7FF) && (r_unpk.val[51:0] != 52'd0);
        sh  = 6'd29;
        w   = '0;
        case (r_unpk.kind)
            K_INT_FLT: begin
                n_mid.lz  = lead_zeros(r_unpk.val);
                n_mid.val = r_unpk.val << n_mid.lz;
            end
            K_F64_F32: begin
                n_mid.nan  = nan;
                n_mid.big  = (e >= 11'd1151);
                n_mid.exp8 = (e >= 11'd897) ? 8'(e - 11'd896) : 8'd0;
                if (e >= 11'd897) begin
                    sh = 6'd29;
                end else if (e <= 11'd862) begin
                    sh = 6'd63;
                end else begin
                    sh = 6'(11'd926 - e);
                end
                w         = {sig, 64'd0} >> sh;
                n_mid.val = nan ? r_unpk.val : {40'd0, w[87:64]};
                n_mid.grd = w[63];
                n_mid.stk = |w[62:0];
            end
            K_FLT_INT: begin
                n_mid.nan = nan;
                n_mid.big = (e >= 11'd1087);
                if (e < 11'd1023) begin
                    n_mid.val = '0;
                end else if (e >= 11'd1075) begin
                    n_mid.val = {11'd0, sig} << (e - 11'd1075);
                end else begin
                    n_mid.val = {11'd0, sig} >> (11'd1075 - e);
                end
            end
            default: begin
                n_mid.val = r_unpk.val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
    end

    ntc_round u_round (
        .i_mid           (r_mid),
        .o_result_bits   (n_res),
        .o_range_clipped (n_clip)
    );

    // result register
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_inv  <= r_mid.inv;
        r_clip <= n_clip;
    end

    assign o_strobe        = r_strobe;
    assign o_result_bits   = r_res;
    assign o_pair_invalid  = r_inv;
    assign o_range_clipped = r_clip;

endmodule
`default_nettype wire

// ===== rtl/ntc_checker.sv =====
`default_nettype none
`include "numeric_type_converter_defines.svh"
module ntc_checker
    import ntc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [3:0]  i_source_type,
    input wire logic [3:0]  i_target_type,
    input wire logic        o_strobe,
    input wire logic [63:0] o_result_bits,
    input wire logic        o_pair_invalid,
    input wire logic        o_range_clipped
);

    logic acc;
    logic bad_pair;

    assign acc      = start && !busy;
    assign bad_pair = !code_valid(i_source_type) || !code_valid(i_target_type);

    // every accepted beat produces a result strobe
    `NTC_CHECK_LAT(a_lat, acc, o_strobe, "accepted beat did not produce a result")
    // no result without a matching accepted beat
    `NTC_CHECK_NOW(a_src, o_strobe, $past(acc, 4), "result without an input beat")
    // unknown pair gives flagged zero result
    `NTC_CHECK_LAT(a_inv, acc && bad_pair, o_pair_invalid && o_result_bits == 64'd0 &&
        !o_range_clipped, "unknown type pair not flagged")
    // single target keeps upper half clear
    `NTC_CHECK_LAT(a_f32, acc && !bad_pair && i_target_type == TC_F32,
        o_result_bits[63:32] == 32'd0, "single result has upper bits set")

endmodule

bind numeric_type_converter ntc_checker u_ntc_checker (.*);
`default_nettype wire
